@@ design/nnue_accumulate_and_evaluate_assert.svh @@
// Assertion macros for the neural evaluator.
`ifndef NNUE_ACCUMULATE_AND_EVALUATE_ASSERT_SVH
`define NNUE_ACCUMULATE_AND_EVALUATE_ASSERT_SVH
// Implication check, disabled in reset.
`define NNUE_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication check, disabled in reset.
`define NNUE_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

@@ design/nnue_pkg.sv @@
// Shared types and constants of the neural evaluator.
package nnue_pkg;
   localparam int FEATURE_COUNT = 40960;
   localparam int ACC_WIDTH     = 64;
   localparam int HIDDEN_WIDTH  = 32;
   localparam int IN_WIDTH      = 2 * ACC_WIDTH;
   localparam int ACC_AW        = $clog2(ACC_WIDTH);
   localparam int HID_AW        = $clog2(HIDDEN_WIDTH);
   localparam int IN_AW         = $clog2(IN_WIDTH);
   localparam int FW_AW         = $clog2(FEATURE_COUNT * ACC_WIDTH);
   localparam int HW_AW         = $clog2(IN_WIDTH * HIDDEN_WIDTH);
   localparam int SUM_W         = 48;

   localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] ACC_MIN = -24'sh800000;
   localparam logic [8:0] ONE_Q = 9'd256;

   typedef enum logic [2:0] {
      ACT_WRITE   = 3'd0,
      ACT_REFRESH = 3'd1,
      ACT_ADD     = 3'd2,
      ACT_REMOVE  = 3'd3,
      ACT_EVAL    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      TBL_FW = 3'd0,
      TBL_FB = 3'd1,
      TBL_HW = 3'd2,
      TBL_HB = 3'd3,
      TBL_OW = 3'd4,
      TBL_OB = 3'd5
   } table_type;

   // Multiply-accumulate unit control.
   typedef struct packed {
      logic                     clear;
      logic signed [SUM_W-1:0]  init;
      logic                     step;
      logic [8:0]               act;
      logic signed [15:0]       wgt;
   } mac_ctl_type;

   // Clamp to 0..256.
   function automatic logic [8:0] clamp_unit(input logic signed [SUM_W-1:0] v);
      logic [8:0] r;
      if (v < 0) r = 9'd0;
      else if (v > $signed({{(SUM_W-9){1'b0}}, ONE_Q})) r = ONE_Q;
      else r = v[8:0];
      return r;
   endfunction
endpackage

@@ design/nnue_mac.sv @@
// Shared multiply-accumulate unit: 9-bit activation times 16-bit weight.
module nnue_mac (
   input  logic                                clock,
   input  nnue_pkg::mac_ctl_type               ctl,
   output logic signed [nnue_pkg::SUM_W-1:0]   sum
);
   logic signed [nnue_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic signed [25:0] prod;

   always_comb begin
      prod = $signed({1'b0, ctl.act}) * ctl.wgt;
      sum_in = sum_ff;
      if (ctl.clear) sum_in = ctl.init;
      else if (ctl.step) sum_in = sum_ff + {{(nnue_pkg::SUM_W-26){prod[25]}}, prod};
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;
endmodule

@@ design/nnue_accumulate_and_evaluate.sv @@
// Neural evaluator: after reset the 2*ACC_WIDTH (128) accumulator entries are cleared with
// req_tready low. A parameter write or an ignored word goes straight to the response state.
// Refresh, add and remove use a read state and a write state per element through one
// accumulator RAM port. Evaluate computes HIDDEN_WIDTH dense sums: each loads its bias, runs one
// multiply-accumulate per input on the shared unit, and stores the clamped sum. The output sum
// then accumulates over the hidden units. A word waits while the previous result is still held
// unaccepted.
// The feature-weight memory is not cleared; entries must be written before use.
`include "nnue_accumulate_and_evaluate_assert.svh"
module nnue_accumulate_and_evaluate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], table_select[5:3], feature_index[21:6], element_index[28:22],
   // param_value[44:29], perspective[45], zeros[47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // score[31:0]
   output logic [31:0] rsp_tdata,
   // score_valid
   output logic        rsp_tuser
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_AREAD = 8'b00000010,
      ST_AWRT  = 8'b00000100,
      ST_HINIT = 8'b00001000,
      ST_HMAC  = 8'b00010000,
      ST_HEND  = 8'b00100000,
      ST_OUT   = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   // Input fields.
   logic [2:0]         f_action, f_table;
   logic [15:0]        f_feat;
   logic [6:0]         f_elem;
   logic signed [15:0] f_val;
   logic               f_side;
   assign f_action = req_tdata[2:0];
   assign f_table  = req_tdata[5:3];
   assign f_feat   = req_tdata[21:6];
   assign f_elem   = req_tdata[28:22];
   assign f_val    = req_tdata[44:29];
   assign f_side   = req_tdata[45];

   // Memories.
   logic signed [15:0] fw_mem [nnue_pkg::FEATURE_COUNT*nnue_pkg::ACC_WIDTH];
   logic signed [15:0] hw_mem [nnue_pkg::IN_WIDTH*nnue_pkg::HIDDEN_WIDTH];
   logic signed [23:0] acc_mem [nnue_pkg::IN_WIDTH];
   logic signed [15:0] fb_mem [nnue_pkg::ACC_WIDTH];
   logic signed [15:0] hb_mem [nnue_pkg::HIDDEN_WIDTH];
   logic signed [15:0] ow_mem [nnue_pkg::HIDDEN_WIDTH];
   logic [8:0]         h_mem  [nnue_pkg::HIDDEN_WIDTH];
   logic signed [15:0] ob_ff;

   state_type state_ff, state_in;
   logic [2:0]  act_ff;
   logic        side_ff;
   logic [15:0] feat_ff;
   logic [nnue_pkg::IN_AW:0]  i_ff;      // element / input position
   logic [nnue_pkg::HID_AW:0] j_ff;      // hidden unit
   logic        rdv_ff;                  // read data valid in pipeline
   logic signed [15:0] fw_rd_ff, fb_rd_ff, hw_rd_ff, hb_rd_ff, ow_rd_ff;
   logic signed [23:0] acc_rd_ff;
   logic [8:0]  h_rd_ff;
   logic        ovld_ff;
   logic [31:0] score_ff;
   logic        rsp_valid_ff;
   logic        clr_pend_ff;
   logic [nnue_pkg::IN_AW:0] clr_ff;

   nnue_pkg::mac_ctl_type mac_ctl;
   logic signed [nnue_pkg::SUM_W-1:0] mac_sum;
   nnue_mac u_mac (.clock(clock), .ctl(mac_ctl), .sum(mac_sum));

   // Read addresses.
   logic [nnue_pkg::ACC_AW-1:0] ea;
   logic [nnue_pkg::IN_AW-1:0]  acc_ra;
   logic [nnue_pkg::HID_AW-1:0] ja;
   logic [nnue_pkg::IN_AW-1:0]  pa;
   assign ea = i_ff[nnue_pkg::ACC_AW-1:0];
   assign ja = j_ff[nnue_pkg::HID_AW-1:0];
   assign pa = i_ff[nnue_pkg::IN_AW-1:0];
   // Evaluate reads side-to-move half first, then opponent half.
   always_comb begin
      if (state_ff == ST_HMAC)
         acc_ra = {pa[nnue_pkg::IN_AW-1] ^ side_ff, pa[nnue_pkg::ACC_AW-1:0]};
      else
         acc_ra = {side_ff, ea};
   end

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !clr_pend_ff;
   assign accept = req_tvalid && req_tready;

   // Write results of accumulator update.
   logic signed [24:0] upd;
   logic signed [23:0] upd_sat, acc_wd;
   always_comb begin
      if (act_ff == nnue_pkg::ACT_ADD)
         upd = $signed({acc_rd_ff[23], acc_rd_ff}) + $signed({{9{fw_rd_ff[15]}}, fw_rd_ff});
      else
         upd = $signed({acc_rd_ff[23], acc_rd_ff}) - $signed({{9{fw_rd_ff[15]}}, fw_rd_ff});
      if (upd > $signed({nnue_pkg::ACC_MAX[23], nnue_pkg::ACC_MAX})) upd_sat = nnue_pkg::ACC_MAX;
      else if (upd < $signed({nnue_pkg::ACC_MIN[23], nnue_pkg::ACC_MIN}))
         upd_sat = nnue_pkg::ACC_MIN;
      else upd_sat = upd[23:0];
      if (act_ff == nnue_pkg::ACT_REFRESH) acc_wd = {{8{fb_rd_ff[15]}}, fb_rd_ff};
      else acc_wd = upd_sat;
   end

   // Dense sum scaled by 1/256 (arithmetic shift is floor).
   logic signed [nnue_pkg::SUM_W-1:0] sum_q;
   assign sum_q = mac_sum >>> 8;

   // Memory ports.
   always_ff @(posedge clock) begin
      fw_rd_ff  <= fw_mem[{feat_ff[nnue_pkg::FW_AW-nnue_pkg::ACC_AW-1:0], ea}];
      fb_rd_ff  <= fb_mem[ea];
      acc_rd_ff <= acc_mem[acc_ra];
      hw_rd_ff  <= hw_mem[{pa, ja}];
      hb_rd_ff  <= hb_mem[ja];
      ow_rd_ff  <= ow_mem[ja];
      h_rd_ff   <= h_mem[ja];
      if (accept && f_action == nnue_pkg::ACT_WRITE) begin
         case (f_table)
            nnue_pkg::TBL_FW:
               if (f_feat < nnue_pkg::FEATURE_COUNT && f_elem < nnue_pkg::ACC_WIDTH)
                  fw_mem[{f_feat[nnue_pkg::FW_AW-nnue_pkg::ACC_AW-1:0],
                          f_elem[nnue_pkg::ACC_AW-1:0]}] <= f_val;
            nnue_pkg::TBL_FB:
               if (f_elem < nnue_pkg::ACC_WIDTH) fb_mem[f_elem[nnue_pkg::ACC_AW-1:0]] <= f_val;
            nnue_pkg::TBL_HW:
               if (f_feat < nnue_pkg::IN_WIDTH && f_elem < nnue_pkg::HIDDEN_WIDTH)
                  hw_mem[{f_feat[nnue_pkg::IN_AW-1:0], f_elem[nnue_pkg::HID_AW-1:0]}] <= f_val;
            nnue_pkg::TBL_HB:
               if (f_elem < nnue_pkg::HIDDEN_WIDTH) hb_mem[f_elem[nnue_pkg::HID_AW-1:0]] <= f_val;
            nnue_pkg::TBL_OW:
               if (f_elem < nnue_pkg::HIDDEN_WIDTH) ow_mem[f_elem[nnue_pkg::HID_AW-1:0]] <= f_val;
            nnue_pkg::TBL_OB: ob_ff <= f_val;
            default: ;
         endcase
      end
      if (clr_pend_ff)
         acc_mem[clr_ff[nnue_pkg::IN_AW-1:0]] <= 24'sd0;
      else if (state_ff == ST_AWRT)
         acc_mem[{side_ff, ea}] <= acc_wd;
      if (state_ff == ST_HEND)
         h_mem[ja] <= nnue_pkg::clamp_unit(sum_q);
   end

   // Sequencer and MAC control.
   always_comb begin
      state_in = state_ff;
      mac_ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (f_action == nnue_pkg::ACT_REFRESH ||
                   ((f_action == nnue_pkg::ACT_ADD || f_action == nnue_pkg::ACT_REMOVE) &&
                    f_feat < nnue_pkg::FEATURE_COUNT))
                  state_in = ST_AREAD;
               else if (f_action == nnue_pkg::ACT_EVAL)
                  state_in = ST_HINIT;
               else
                  state_in = ST_RESP;
            end
         end
         ST_AREAD: state_in = ST_AWRT;
         ST_AWRT: begin
            if (i_ff == nnue_pkg::ACC_WIDTH - 1) state_in = ST_RESP;
            else state_in = ST_AREAD;
         end
         ST_HINIT: begin
            // hb read registered this cycle; load bias*256 when valid
            if (j_ff == nnue_pkg::HIDDEN_WIDTH) state_in = ST_OUT;
            else if (rdv_ff) begin
               mac_ctl.clear = 1'b1;
               mac_ctl.init = {{(nnue_pkg::SUM_W-24){hb_rd_ff[15]}}, hb_rd_ff, 8'd0};
               state_in = ST_HMAC;
            end
         end
         ST_HMAC: begin
            mac_ctl.step = rdv_ff;
            mac_ctl.act  = nnue_pkg::clamp_unit({{(nnue_pkg::SUM_W-24){acc_rd_ff[23]}},
                                                 acc_rd_ff});
            mac_ctl.wgt  = hw_rd_ff;
            if (i_ff == nnue_pkg::IN_WIDTH) state_in = ST_HEND;
         end
         ST_HEND: state_in = ST_HINIT;
         ST_OUT: begin
            if (!ovld_ff) begin
               mac_ctl.clear = 1'b1;
               mac_ctl.init = {{(nnue_pkg::SUM_W-24){ob_ff[15]}}, ob_ff, 8'd0};
            end else begin
               mac_ctl.step = rdv_ff;
               mac_ctl.act  = h_rd_ff;
               mac_ctl.wgt  = ow_rd_ff;
               if (j_ff == nnue_pkg::HIDDEN_WIDTH && !rdv_ff) state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_pend_ff  <= 1'b1;
         clr_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rdv_ff       <= 1'b0;
         ovld_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_pend_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == nnue_pkg::IN_WIDTH - 1) clr_pend_ff <= 1'b0;
         end
         // result valid: load a new word or drop the accepted one
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               i_ff <= '0;
               j_ff <= '0;
               rdv_ff <= 1'b0;
               ovld_ff <= 1'b0;
               if (accept) begin
                  act_ff  <= f_action;
                  side_ff <= f_side;
                  feat_ff <= f_feat;
                  score_ff <= '0;
               end
            end
            ST_AWRT: i_ff <= i_ff + 1'b1;
            ST_HINIT: begin
               i_ff <= '0;
               rdv_ff <= ~rdv_ff & (j_ff != nnue_pkg::HIDDEN_WIDTH);
            end
            ST_HMAC: begin
               // Address i_ff issued now; data valid next cycle.
               if (i_ff != nnue_pkg::IN_WIDTH) begin
                  i_ff <= i_ff + 1'b1;
                  rdv_ff <= 1'b1;
               end else rdv_ff <= 1'b0;
            end
            ST_HEND: j_ff <= j_ff + 1'b1;
            ST_OUT: begin
               if (!ovld_ff) begin
                  ovld_ff <= 1'b1;
                  j_ff <= '0;
                  rdv_ff <= 1'b0;
               end else begin
                  if (j_ff != nnue_pkg::HIDDEN_WIDTH) begin
                     j_ff <= j_ff + 1'b1;
                     rdv_ff <= 1'b1;
                  end else rdv_ff <= 1'b0;
               end
            end
            default: ;
         endcase
         if (state_ff == ST_OUT && state_in == ST_RESP) begin
            if (sum_q > 48'sh7FFFFFFF) score_ff <= 32'h7FFFFFFF;
            else if (sum_q < -48'sh80000000) score_ff <= 32'h80000000;
            else score_ff <= sum_q[31:0];
         end
      end
   end

   // Output register.
   logic        osv_ff;
   logic [31:0] osc_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) begin
         osv_ff <= (act_ff == nnue_pkg::ACT_EVAL);
         osc_ff <= score_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = osc_ff;
   assign rsp_tuser  = osv_ff;

   `NNUE_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `NNUE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `NNUE_ASSERT_IMP(a_clear_idle, clock, reset, clr_pend_ff, state_ff == ST_IDLE)
endmodule
